// File: rtl/rrts_pkg.sv
// shared types, codes and constants of the round-robin task scheduler
// no dependencies; used by rrts_queue, rrts_task_table and the top level
`default_nettype none

package rrts_pkg;

  // sizes fixed by the field widths
  localparam int RRTS_MAX_TASKS = 16;
  localparam int NUM_IDS        = 16;
  localparam int ID_W           = 4;
  localparam int PRIO_W         = 8;

  // reset contents
  localparam logic [ID_W-1:0]   RST_MAIN_ID   = 4'd0;
  localparam logic [ID_W-1:0]   RST_IDLE_ID   = 4'd1;
  localparam logic [PRIO_W-1:0] MAIN_PRIORITY = 8'd31;
  localparam logic [PRIO_W-1:0] IDLE_PRIORITY = 8'd10;

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_PREEMPT = 3'd1,
    CMD_YIELD   = 3'd2,
    CMD_BLOCK   = 3'd3,
    CMD_UNBLOCK = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    TS_UNUSED  = 3'd0,
    TS_RUNNING = 3'd1,
    TS_READY   = 3'd2,
    TS_BLOCKED = 3'd3,
    TS_WAITING = 3'd4,
    TS_HANGING = 3'd5
  } task_state_t;

  typedef enum logic [1:0] {
    BS_BLOCKED = 2'd0,
    BS_WAITING = 2'd1,
    BS_HANGING = 2'd2,
    BS_INVALID = 2'd3
  } block_status_t;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_STATUS  = 2'd1,
    ERR_UNBLOCK = 2'd2,
    ERR_FULL    = 2'd3
  } err_t;

  // deque operations for one transaction
  typedef struct packed {
    logic            append;
    logic            push_front;
    logic            pop;
    logic [ID_W-1:0] id;
  } qctl_t;

  // deque status
  typedef struct packed {
    logic            full;
    logic            empty;
    logic [ID_W-1:0] head_id;
  } qstat_t;

  // task table updates for one transaction
  typedef struct packed {
    logic              prio_wr;
    logic              ready_wr;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic              cur_wr;
    logic [ID_W-1:0]   cur_id;
    task_state_t       cur_state;
    logic              next_wr;
    logic [ID_W-1:0]   next_id;
  } tctl_t;

endpackage

`default_nettype wire

// File: rtl/round_robin_task_scheduler_core.sv
// round-robin task scheduler: input register, command decode, result register
// depends on rrts_pkg, rrts_queue and rrts_task_table
//
// usage:
//   the input channel (in_valid / in_stall) carries one command per transaction:
//   create, preempt, yield, block or unblock, with task number, priority and
//   block status. every command gives exactly one result transaction on the
//   output channel (out_valid / out_stall): running task, switch flag, tick
//   reload and error code.
//   cfg_we / cfg_wdata write the idle task number; write it only while no
//   command is in flight.
//   the command waits in the input register and is decoded from there; the
//   result register loads when it is decoded, which a receiver stall can hold off.
//   throughput: one command per cycle while the receiver does not stall; the
//   deque head is kept registered and the tables are updated in the same cycle,
//   so nothing else limits the rate below that.
//   reset (rst_n low, synchronous): task 0 runs, the deque holds task 1, the
//   idle task is 1, both channels empty.
//   when the receiver stalls, the result register holds and the input register
//   fills; in_stall rises once both are occupied.
`default_nettype none

module round_robin_task_scheduler_core #(
  parameter int MAX_TASKS = rrts_pkg::RRTS_MAX_TASKS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic [rrts_pkg::ID_W-1:0]   cfg_wdata,
  // command channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  in_cmd,
  input  wire logic [rrts_pkg::ID_W-1:0]   in_task_id,
  input  wire logic [rrts_pkg::PRIO_W-1:0] in_priority_req,
  input  wire logic [1:0]                  in_block_status,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [rrts_pkg::ID_W-1:0]        out_running_id,
  output logic                             out_switched,
  output logic                             out_reload_valid,
  output logic [rrts_pkg::PRIO_W-1:0]      out_reload_ticks,
  output logic [1:0]                       out_error
);
  import rrts_pkg::*;

  // input register
  logic              in_vld_r;
  logic [2:0]        cmd_r;
  logic [ID_W-1:0]   id_r;
  logic [PRIO_W-1:0] prio_r;
  logic [1:0]        bstat_r;

  // result register
  logic              out_vld_r;
  logic [ID_W-1:0]   out_run_r;
  logic              out_sw_r;
  logic              out_rv_r;
  logic [PRIO_W-1:0] out_rt_r;
  logic [1:0]        out_err_r;

  // scheduler registers
  logic [ID_W-1:0]   cur_r;
  logic [ID_W-1:0]   idle_r;

  logic              in_accept;
  logic              proc;

  qctl_t             qctl;
  qstat_t            qstat;
  tctl_t             tctl;
  task_state_t       id_state;
  logic [PRIO_W-1:0] cur_prio;

  logic              sw;
  logic [ID_W-1:0]   next_id;
  logic              rvalid;
  logic [PRIO_W-1:0] rticks;
  err_t              err;
  cmd_t              cmd_e;
  block_status_t     bstat_e;
  logic              id_parked;

  // handshake: decode when the result register is free or being emptied
  assign proc      = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall  = in_vld_r & ~proc;
  assign in_accept = in_valid & ~in_stall;

  // idle task register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r <= RST_IDLE_ID;
    end else if (cfg_we) begin
      idle_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_accept | (in_vld_r & ~proc);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r   <= in_cmd;
      id_r    <= in_task_id;
      prio_r  <= in_priority_req;
      bstat_r <= in_block_status;
    end
  end

  // tables and deque
  rrts_task_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (tctl),
    .rd_id    (id_r),
    .cur_id   (cur_r),
    .rd_state (id_state),
    .cur_prio (cur_prio)
  );

  rrts_queue #(
    .MAX_TASKS (MAX_TASKS)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (qctl),
    .stat  (qstat)
  );

  assign cmd_e     = cmd_t'(cmd_r);
  assign bstat_e   = block_status_t'(bstat_r);
  assign id_parked = (id_state == TS_BLOCKED) || (id_state == TS_WAITING) ||
                     (id_state == TS_HANGING);

  // command decode
  always_comb begin
    qctl   = '0;
    tctl   = '0;
    tctl.id        = id_r;
    tctl.prio      = prio_r;
    tctl.cur_id    = cur_r;
    tctl.cur_state = TS_READY;
    sw      = 1'b0;
    next_id = cur_r;
    rvalid  = 1'b0;
    rticks  = '0;
    err     = ERR_OK;

    unique case (cmd_e)
      CMD_CREATE: begin
        if (id_state == TS_READY || id_state == TS_RUNNING) begin
          tctl.prio_wr = 1'b1;
        end else if (qstat.full) begin
          err = ERR_FULL;
        end else begin
          tctl.prio_wr  = 1'b1;
          tctl.ready_wr = 1'b1;
          qctl.append   = 1'b1;
          qctl.id       = id_r;
        end
      end
      CMD_PREEMPT, CMD_YIELD: begin
        if (qstat.full) begin
          err = ERR_FULL;
        end else begin
          // running task goes to the tail, then the head is taken
          tctl.cur_wr = 1'b1;
          qctl.append = 1'b1;
          qctl.pop    = 1'b1;
          qctl.id     = cur_r;
          next_id     = qstat.empty ? cur_r : qstat.head_id;
          sw          = 1'b1;
          if (cmd_e == CMD_PREEMPT) begin
            rvalid = 1'b1;
            rticks = cur_prio;
          end
        end
      end
      CMD_BLOCK: begin
        if (bstat_e == BS_INVALID) begin
          err = ERR_STATUS;
        end else begin
          tctl.cur_wr = 1'b1;
          unique case (bstat_e)
            BS_WAITING: tctl.cur_state = TS_WAITING;
            BS_HANGING: tctl.cur_state = TS_HANGING;
            default:    tctl.cur_state = TS_BLOCKED;
          endcase
          // empty deque wakes the idle task
          qctl.pop = ~qstat.empty;
          next_id  = qstat.empty ? idle_r : qstat.head_id;
          sw       = 1'b1;
        end
      end
      CMD_UNBLOCK: begin
        if (id_state == TS_READY) begin
          // already queued, nothing to do
        end else if (!id_parked) begin
          err = ERR_UNBLOCK;
        end else if (qstat.full) begin
          err = ERR_FULL;
        end else begin
          tctl.ready_wr   = 1'b1;
          qctl.push_front = 1'b1;
          qctl.id         = id_r;
        end
      end
      default: begin
        // unused command codes do nothing
      end
    endcase

    tctl.next_wr = sw;
    tctl.next_id = next_id;

    // nothing changes unless a command is being decoded
    if (!proc) begin
      qctl = '0;
      tctl.prio_wr  = 1'b0;
      tctl.ready_wr = 1'b0;
      tctl.cur_wr   = 1'b0;
      tctl.next_wr  = 1'b0;
    end
  end

  // running task
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= RST_MAIN_ID;
    end else if (proc && sw) begin
      cur_r <= next_id;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_run_r <= next_id;
      out_sw_r  <= sw;
      out_rv_r  <= rvalid;
      out_rt_r  <= rticks;
      out_err_r <= err;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_running_id   = out_run_r;
  assign out_switched     = out_sw_r;
  assign out_reload_valid = out_rv_r;
  assign out_reload_ticks = out_rt_r;
  assign out_error        = out_err_r;

  // a switch never comes with an error
  a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_sw_r) |-> (out_err_r == ERR_OK))
    else $error("switch reported together with an error");

  // a reload only comes with a switch
  a_reload_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_rv_r) |-> out_sw_r)
    else $error("tick reload without a task switch");

  // the reported running task is the one now held
  a_running_match: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && sw) |=> (out_run_r == cur_r))
    else $error("result running task differs from the scheduler register");

endmodule

`default_nettype wire

// File: rtl/rrts_queue.sv
// ready deque: circular memory of task numbers with head and count
// depends on rrts_pkg; the head entry is kept in a register so pops need no memory read
`default_nettype none

module rrts_queue #(
  parameter int MAX_TASKS = rrts_pkg::RRTS_MAX_TASKS
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rrts_pkg::qctl_t ctl,
  output rrts_pkg::qstat_t    stat
);
  import rrts_pkg::*;

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [AW:0]   DEPTH = MAX_TASKS[AW:0];
  localparam logic [AW-1:0] LAST  = AW'(MAX_TASKS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TASKS);

  logic [ID_W-1:0] mem [MAX_TASKS];
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [ID_W-1:0] head_id_r;
  logic            init0_r;

  logic [AW:0]     tail_sum, tail_wrap;
  logic [AW-1:0]   tail_a, head_inc, head_dec, wr_addr;
  logic            wr_en;

  // tail position and head neighbors, all modulo the depth
  assign tail_sum  = {1'b0, head_r} + (AW+1)'(cnt_r);
  assign tail_wrap = (tail_sum >= DEPTH) ? (tail_sum - DEPTH) : tail_sum;
  assign tail_a    = tail_wrap[AW-1:0];
  assign head_inc  = (head_r == LAST) ? '0 : head_r + 1'b1;
  assign head_dec  = (head_r == '0) ? LAST : head_r - 1'b1;

  // write port
  assign wr_en   = ctl.append | ctl.push_front;
  assign wr_addr = ctl.push_front ? head_dec : tail_a;

  // next head and count
  always_comb begin
    if (ctl.push_front) begin
      head_nxt = head_dec;
    end else if (ctl.pop) begin
      head_nxt = head_inc;
    end else begin
      head_nxt = head_r;
    end
  end

  always_comb begin
    unique case ({wr_en, ctl.pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= ctl.id;
    end
  end

  // pointers and the registered head entry; entry 0 holds the idle task after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      cnt_r     <= CW'(1);
      head_id_r <= RST_IDLE_ID;
      init0_r   <= 1'b1;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      if (wr_en && wr_addr == head_nxt) begin
        head_id_r <= ctl.id;
      end else if (init0_r && head_nxt == '0) begin
        head_id_r <= RST_IDLE_ID;
      end else begin
        head_id_r <= mem[head_nxt];
      end
      if (wr_en && wr_addr == '0) begin
        init0_r <= 1'b0;
      end
    end
  end

  assign stat.full    = (cnt_r == FULL_CNT);
  assign stat.empty   = (cnt_r == '0);
  assign stat.head_id = head_id_r;

  // no growth of a full deque
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !ctl.pop) |-> !stat.full)
    else $error("deque written while full");

  // no pop of an empty deque
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.pop && !wr_en) |-> !stat.empty)
    else $error("deque popped while empty");

endmodule

`default_nettype wire

// File: rtl/rrts_task_table.sv
// per-task status and priority tables, one entry per task number
// depends on rrts_pkg; flip-flop arrays with reset contents
`default_nettype none

module rrts_task_table (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire rrts_pkg::tctl_t        ctl,
  input  wire logic [rrts_pkg::ID_W-1:0] rd_id,
  input  wire logic [rrts_pkg::ID_W-1:0] cur_id,
  output rrts_pkg::task_state_t       rd_state,
  output logic [rrts_pkg::PRIO_W-1:0] cur_prio
);
  import rrts_pkg::*;

  task_state_t       state_r [NUM_IDS];
  logic [PRIO_W-1:0] prio_r  [NUM_IDS];

  // status entries; the dispatched task wins over the one it replaces
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_IDS; i++) begin
        if (ID_W'(i) == RST_MAIN_ID) begin
          state_r[i] <= TS_RUNNING;
        end else if (ID_W'(i) == RST_IDLE_ID) begin
          state_r[i] <= TS_READY;
        end else begin
          state_r[i] <= TS_UNUSED;
        end
      end
    end else begin
      for (int i = 0; i < NUM_IDS; i++) begin
        if (ctl.next_wr && ctl.next_id == ID_W'(i)) begin
          state_r[i] <= TS_RUNNING;
        end else if (ctl.cur_wr && ctl.cur_id == ID_W'(i)) begin
          state_r[i] <= ctl.cur_state;
        end else if (ctl.ready_wr && ctl.id == ID_W'(i)) begin
          state_r[i] <= TS_READY;
        end
      end
    end
  end

  // priority entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_IDS; i++) begin
        if (ID_W'(i) == RST_MAIN_ID) begin
          prio_r[i] <= MAIN_PRIORITY;
        end else if (ID_W'(i) == RST_IDLE_ID) begin
          prio_r[i] <= IDLE_PRIORITY;
        end else begin
          prio_r[i] <= '0;
        end
      end
    end else if (ctl.prio_wr) begin
      prio_r[ctl.id] <= ctl.prio;
    end
  end

  assign rd_state = state_r[rd_id];
  assign cur_prio = prio_r[cur_id];

endmodule

`default_nettype wire

// File: tb/round_robin_task_scheduler_core_test.sv
// testbench for round_robin_task_scheduler_core: random and directed scheduler commands
// a scoreboard class predicts the running task, switch, reload and error of each command
// depends on rrts_pkg and the round_robin_task_scheduler_core rtl
`timescale 1ns / 100ps

import rrts_pkg::*;

// one command transaction as offered on the input channel
typedef struct packed {
  logic [2:0]        cmd;
  logic [ID_W-1:0]   task_id;
  logic [PRIO_W-1:0] prio;
  logic [1:0]        bstat;
} sched_cmd_t;

// one result transaction of the output channel
typedef struct packed {
  logic [ID_W-1:0]   running_id;
  logic              switched;
  logic              reload_valid;
  logic [PRIO_W-1:0] reload_ticks;
  err_t              error;
} dispatch_t;

class dispatch_scoreboard;
  task_state_t       tstate [NUM_IDS];
  logic [PRIO_W-1:0] prio_tbl [NUM_IDS];
  logic [ID_W-1:0]   ring [RRTS_MAX_TASKS];
  int unsigned       q_head;
  int unsigned       q_count;
  logic [ID_W-1:0]   current;
  logic [ID_W-1:0]   idle;
  dispatch_t         expected_dispatches [$];
  int                errors;

  function new();
    for (int i = 0; i < NUM_IDS; i++) begin
      tstate[i]   = TS_UNUSED;
      prio_tbl[i] = '0;
    end
    for (int i = 0; i < RRTS_MAX_TASKS; i++) ring[i] = '0;
    tstate[RST_MAIN_ID]   = TS_RUNNING;
    tstate[RST_IDLE_ID]   = TS_READY;
    prio_tbl[RST_MAIN_ID] = MAIN_PRIORITY;
    prio_tbl[RST_IDLE_ID] = IDLE_PRIORITY;
    ring[0] = RST_IDLE_ID;
    q_head  = 0;
    q_count = 1;
    current = RST_MAIN_ID;
    idle    = RST_IDLE_ID;
    errors  = 0;
  endfunction

  function void set_idle(logic [ID_W-1:0] v);
    idle = v;
  endfunction

  function int pending();
    return expected_dispatches.size();
  endfunction

  function bit is_parked(logic [ID_W-1:0] id);
    return tstate[id] == TS_BLOCKED || tstate[id] == TS_WAITING ||
           tstate[id] == TS_HANGING;
  endfunction

  function void append_tail(logic [ID_W-1:0] id);
    ring[(q_head + q_count) % RRTS_MAX_TASKS] = id;
    q_count++;
  endfunction

  // pop the head into the running slot, or wake the idle task
  function void run_next();
    logic [ID_W-1:0] nxt;
    if (q_count == 0) begin
      nxt = idle;
    end else begin
      nxt = ring[q_head];
      q_head = (q_head + 1) % RRTS_MAX_TASKS;
      q_count--;
    end
    tstate[nxt] = TS_RUNNING;
    current = nxt;
  endfunction

  function dispatch_t predict_dispatch(sched_cmd_t c);
    dispatch_t       r;
    bit              full;
    logic [ID_W-1:0] cur;
    r.switched     = 1'b0;
    r.reload_valid = 1'b0;
    r.reload_ticks = '0;
    r.error        = ERR_OK;
    full = (q_count >= RRTS_MAX_TASKS);
    cur  = current;
    case (c.cmd)
      CMD_CREATE: begin
        if (tstate[c.task_id] == TS_READY || tstate[c.task_id] == TS_RUNNING) begin
          prio_tbl[c.task_id] = c.prio;
        end else if (full) begin
          r.error = ERR_FULL;
        end else begin
          prio_tbl[c.task_id] = c.prio;
          tstate[c.task_id] = TS_READY;
          append_tail(c.task_id);
        end
      end
      CMD_PREEMPT, CMD_YIELD: begin
        if (full) begin
          r.error = ERR_FULL;
        end else begin
          tstate[cur] = TS_READY;
          append_tail(cur);
          if (c.cmd == CMD_PREEMPT) begin
            r.reload_valid = 1'b1;
            r.reload_ticks = prio_tbl[cur];
          end
          run_next();
          r.switched = 1'b1;
        end
      end
      CMD_BLOCK: begin
        if (c.bstat == BS_INVALID) begin
          r.error = ERR_STATUS;
        end else begin
          case (c.bstat)
            BS_BLOCKED: tstate[cur] = TS_BLOCKED;
            BS_WAITING: tstate[cur] = TS_WAITING;
            default:    tstate[cur] = TS_HANGING;
          endcase
          run_next();
          r.switched = 1'b1;
        end
      end
      CMD_UNBLOCK: begin
        // a ready task is left alone without error
        if (tstate[c.task_id] == TS_READY) begin
        end else if (!is_parked(c.task_id)) begin
          r.error = ERR_UNBLOCK;
        end else if (full) begin
          r.error = ERR_FULL;
        end else begin
          tstate[c.task_id] = TS_READY;
          q_head = (q_head + RRTS_MAX_TASKS - 1) % RRTS_MAX_TASKS;
          ring[q_head] = c.task_id;
          q_count++;
        end
      end
      default: begin
      end
    endcase
    r.running_id = current;
    return r;
  endfunction

  function void note_command(sched_cmd_t c);
    expected_dispatches.push_back(predict_dispatch(c));
  endfunction

  function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_dispatch(dispatch_t act);
    dispatch_t e;
    if (expected_dispatches.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual running_id %0d",
               $time, act.running_id);
      errors++;
      return;
    end
    e = expected_dispatches.pop_front();
    compare_field("running_id", 8'(e.running_id), 8'(act.running_id));
    compare_field("switched", 8'(e.switched), 8'(act.switched));
    compare_field("reload_valid", 8'(e.reload_valid), 8'(act.reload_valid));
    compare_field("reload_ticks", e.reload_ticks, act.reload_ticks);
    compare_field("error", 8'(e.error), 8'(act.error));
  endfunction
endclass

module round_robin_task_scheduler_core_test;

  // command codes the block treats as no operation
  localparam logic [2:0] CMD_RSVD_LO  = 3'd5;
  localparam logic [2:0] CMD_RSVD_MID = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI  = 3'd7;

  localparam int PHASE_ITEMS   = 106;
  localparam int NUM_PHASES    = 5;
  localparam int HOLD_AT       = 200;
  localparam int HOLD_CYCLES   = 80;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 4;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [ID_W-1:0]   cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        in_cmd;
  logic [ID_W-1:0]   in_task_id;
  logic [PRIO_W-1:0] in_priority_req;
  logic [1:0]        in_block_status;
  logic              out_valid;
  logic              out_stall;
  logic [ID_W-1:0]   out_running_id;
  logic              out_switched;
  logic              out_reload_valid;
  logic [PRIO_W-1:0] out_reload_ticks;
  logic [1:0]        out_error;

  dispatch_scoreboard sb;
  sched_cmd_t         directed_cmds [$];
  int                 results_seen;
  int                 cycle_count;
  int                 send_burst;
  logic [ID_W-1:0]    idle_values [NUM_PHASES];

  round_robin_task_scheduler_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_task_id       (in_task_id),
    .in_priority_req  (in_priority_req),
    .in_block_status  (in_block_status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_running_id   (out_running_id),
    .out_switched     (out_switched),
    .out_reload_valid (out_reload_valid),
    .out_reload_ticks (out_reload_ticks),
    .out_error        (out_error)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // mostly short gaps, now and then a long one
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // random command, biased toward unblocking tasks that are really parked
  function sched_cmd_t pick_command();
    sched_cmd_t      c;
    logic [ID_W-1:0] parked [$];
    int              r;
    for (int i = 0; i < NUM_IDS; i++)
      if (sb.is_parked(i[ID_W-1:0])) parked.push_back(i[ID_W-1:0]);
    c.task_id = ID_W'($urandom_range(0, NUM_IDS - 1));
    c.prio    = PRIO_W'($urandom_range(0, 255));
    c.bstat   = ($urandom_range(0, 9) == 0) ? BS_INVALID : 2'($urandom_range(0, 2));
    r = $urandom_range(0, 99);
    if (r < 30)      c.cmd = CMD_CREATE;
    else if (r < 48) c.cmd = CMD_PREEMPT;
    else if (r < 62) c.cmd = CMD_YIELD;
    else if (r < 78) c.cmd = CMD_BLOCK;
    else if (r < 95) c.cmd = CMD_UNBLOCK;
    else             c.cmd = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
    if (c.cmd == CMD_UNBLOCK && parked.size() != 0 && $urandom_range(0, 9) < 7)
      c.task_id = parked[$urandom_range(0, parked.size() - 1)];
    return c;
  endfunction

  task add_directed(input logic [2:0] cmd, input int id, input int prio, input int bstat);
    sched_cmd_t c;
    c.cmd     = cmd;
    c.task_id = ID_W'(id);
    c.prio    = PRIO_W'(prio);
    c.bstat   = 2'(bstat);
    directed_cmds.push_back(c);
  endtask

  // offer one transaction after a gap and wait until it is taken
  task send_command(input sched_cmd_t c);
    int gap;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      gap = gap_len();
      if ($urandom_range(0, 19) == 0) send_burst = 30;
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_cmd          = c.cmd;
    in_task_id      = c.task_id;
    in_priority_req = c.prio;
    in_block_status = c.bstat;
    do @(posedge clk); while (in_stall);
    sb.note_command(c);
  endtask

  // stop offering and wait for every result in flight
  task drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task write_idle(input logic [ID_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_idle(v);
  endtask

  // result receiver: random stalls, bursts without stall, one long hold-off
  initial begin
    int  stall_left;
    int  recv_burst;
    bit  hold_done;
    int  g;
    stall_left = 0;
    recv_burst = 0;
    hold_done  = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        out_stall  = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        hold_done  = 1'b1;
      end else if (recv_burst > 0) begin
        out_stall = 1'b0;
        recv_burst--;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_stall  = 1'b1;
          stall_left = g - 1;
        end else begin
          out_stall = 1'b0;
          if ($urandom_range(0, 19) == 0) recv_burst = 30;
        end
      end
    end
  end

  // result monitor
  initial begin
    dispatch_t act;
    results_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        act.running_id   = out_running_id;
        act.switched     = out_switched;
        act.reload_valid = out_reload_valid;
        act.reload_ticks = out_reload_ticks;
        act.error        = err_t'(out_error);
        sb.check_dispatch(act);
        results_seen++;
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("round_robin_task_scheduler_core_test: done, errors");
    $finish;
  end

  // stimulus
  initial begin
    sb = new();
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_cmd          = CMD_CREATE;
    in_task_id      = '0;
    in_priority_req = '0;
    in_block_status = BS_BLOCKED;
    send_burst      = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: creates, priority updates, switches, every block status,
    // unblock of parked, ready, running and unused tasks, reserved codes,
    // draining the queue so the idle task wakes, also when it blocked itself
    add_directed(CMD_CREATE, 15, 255, BS_BLOCKED);
    add_directed(CMD_CREATE, 0, 0, BS_BLOCKED);
    add_directed(CMD_CREATE, 1, 200, BS_BLOCKED);
    add_directed(CMD_CREATE, 2, 128, BS_BLOCKED);
    add_directed(CMD_PREEMPT, 0, 0, BS_BLOCKED);
    add_directed(CMD_YIELD, 0, 0, BS_BLOCKED);
    add_directed(CMD_BLOCK, 0, 0, BS_BLOCKED);
    add_directed(CMD_BLOCK, 0, 0, BS_WAITING);
    add_directed(CMD_BLOCK, 0, 0, BS_INVALID);
    add_directed(CMD_UNBLOCK, 15, 0, BS_BLOCKED);
    add_directed(CMD_UNBLOCK, 1, 0, BS_BLOCKED);
    add_directed(CMD_UNBLOCK, 0, 0, BS_BLOCKED);
    add_directed(CMD_UNBLOCK, 9, 0, BS_BLOCKED);
    add_directed(CMD_RSVD_LO, 5, 85, BS_WAITING);
    add_directed(CMD_RSVD_MID, 10, 170, BS_HANGING);
    add_directed(CMD_RSVD_HI, 15, 255, BS_INVALID);
    add_directed(CMD_BLOCK, 0, 0, BS_HANGING);
    add_directed(CMD_BLOCK, 0, 0, BS_BLOCKED);
    add_directed(CMD_BLOCK, 0, 0, BS_WAITING);
    add_directed(CMD_UNBLOCK, 2, 0, BS_BLOCKED);
    add_directed(CMD_PREEMPT, 0, 0, BS_BLOCKED);
    add_directed(CMD_CREATE, 14, 0, BS_BLOCKED);
    add_directed(CMD_CREATE, 13, 255, BS_HANGING);
    foreach (directed_cmds[i]) send_command(directed_cmds[i]);

    // random phases, each with an idle task written before it
    idle_values[0] = 4'd15;
    idle_values[1] = 4'd0;
    idle_values[2] = ID_W'($urandom_range(2, 14));
    idle_values[3] = RST_IDLE_ID;
    idle_values[4] = ID_W'($urandom_range(0, NUM_IDS - 1));
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_idle(idle_values[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) send_command(pick_command());
    end

    // final drain
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("round_robin_task_scheduler_core_test: done, clean");
    end else begin
      $display("round_robin_task_scheduler_core_test: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rrts_pkg.sv
rtl/rrts_queue.sv
rtl/rrts_task_table.sv
rtl/round_robin_task_scheduler_core.sv
tb/round_robin_task_scheduler_core_test.sv
